>>> design/trnq_pkg.sv
// types and constants shared by the team radius nearest query block
`default_nettype none

package trnq_pkg;

    localparam int unsigned QUEUE_DEPTH_DEF = 4;
    localparam logic [15:0] MIN_COUNT_RST   = 16'd1;
    localparam logic [15:0] COUNT_MAX       = 16'hFFFF;

    typedef enum logic {
        KIND_QUERY = 1'b0,
        KIND_CAND  = 1'b1
    } trnq_kind_t;

    typedef struct packed {
        trnq_kind_t  kind;
        logic [15:0] idx;
        logic        ally;
        logic        last;
        logic        lpos;
        logic [31:0] sqx;
        logic [31:0] sqy;
    } trnq_entry_t;

    typedef struct packed {
        logic [15:0] cand_index;
        logic        in_radius;
        logic [15:0] ally_count;
        logic        nearest_found;
        logic [15:0] nearest_index;
        logic [32:0] nearest_dist_sq;
        logic        nearest_in_limit;
        logic        count_satisfied;
        logic        done_res;
    } trnq_result_t;

endpackage

`default_nettype wire

>>> design/team_radius_nearest_query_top.sv
// top level of the team radius and nearest ally query block
//
//  channel   direction  handshake          payload
//  request   in         push / full        req_type agent_index team_id pos_x pos_y radius last
//  result    out        empty / pop        cand_index .. done_res, one word per candidate
//  config    in         cfg_we             cfg_wdata = min_count
//
//  one word accepted per cycle while full is low; a candidate passes front stage and queue
//  squaring sits in the front stage, sum, compares and nearest update in the back stage
//  full rises when the queue plus the front stage hold QUEUE_DEPTH words
//  a query word produces no result and passes even while the result is stalled
//  reset clears the asker to index 0, team 0, origin, radius 0, and min_count to 1
`default_nettype none

module team_radius_nearest_query_top
    import trnq_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic [15:0]        cfg_wdata,
    input  wire logic               push,
    output logic                    full,
    input  wire logic               req_type,
    input  wire logic [15:0]        agent_index,
    input  wire logic [7:0]         team_id,
    input  wire logic signed [15:0] pos_x,
    input  wire logic signed [15:0] pos_y,
    input  wire logic signed [15:0] radius,
    input  wire logic               last,
    output logic                    empty,
    input  wire logic               pop,
    output logic [15:0]             cand_index,
    output logic                    in_radius,
    output logic [15:0]             ally_count,
    output logic                    nearest_found,
    output logic [15:0]             nearest_index,
    output logic [32:0]             nearest_dist_sq,
    output logic                    nearest_in_limit,
    output logic                    count_satisfied,
    output logic                    done_res
);

    localparam int unsigned LVL_W = $clog2(QUEUE_DEPTH + 1);

    logic             q_wr;
    trnq_entry_t      q_wdata;
    logic             q_rd;
    logic             q_nonempty;
    trnq_entry_t      q_rdata;
    logic [LVL_W-1:0] q_level;
    logic             res_valid;
    trnq_result_t     res;

    trnq_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .req_type    (req_type),
        .agent_index (agent_index),
        .team_id     (team_id),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .radius      (radius),
        .last        (last),
        .q_level     (q_level),
        .q_wr        (q_wr),
        .q_wdata     (q_wdata)
    );

    trnq_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr       (q_wr),
        .wdata    (q_wdata),
        .rd       (q_rd),
        .nonempty (q_nonempty),
        .rdata    (q_rdata),
        .level    (q_level)
    );

    trnq_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .q_nonempty (q_nonempty),
        .q_rdata    (q_rdata),
        .q_rd       (q_rd),
        .res_valid  (res_valid),
        .res        (res),
        .res_pop    (pop)
    );

    assign empty            = !res_valid;
    assign cand_index       = res.cand_index;
    assign in_radius        = res.in_radius;
    assign ally_count       = res.ally_count;
    assign nearest_found    = res.nearest_found;
    assign nearest_index    = res.nearest_index;
    assign nearest_dist_sq  = res.nearest_dist_sq;
    assign nearest_in_limit = res.nearest_in_limit;
    assign count_satisfied  = res.count_satisfied;
    assign done_res         = res.done_res;

endmodule

`default_nettype wire

>>> design/trnq_front.sv
// front end: accepts words, holds the asker, classifies and squares
`default_nettype none

module trnq_front
    import trnq_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    localparam int unsigned LVL_W      = $clog2(QUEUE_DEPTH + 1)
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    output logic                    full,
    input  wire logic               req_type,
    input  wire logic [15:0]        agent_index,
    input  wire logic [7:0]         team_id,
    input  wire logic signed [15:0] pos_x,
    input  wire logic signed [15:0] pos_y,
    input  wire logic signed [15:0] radius,
    input  wire logic               last,
    input  wire logic [LVL_W-1:0]   q_level,
    output logic                    q_wr,
    output trnq_entry_t             q_wdata
);

    localparam logic [LVL_W:0] DEPTH_V = (LVL_W + 1)'(QUEUE_DEPTH);

    logic        accept;
    logic [15:0] self_index_reg, self_index_next;
    logic [7:0]  self_team_reg, self_team_next;
    logic [15:0] self_x_reg, self_x_next;
    logic [15:0] self_y_reg, self_y_next;

    logic        a_valid_reg;
    trnq_kind_t  a_kind_reg, a_kind_next;
    logic [15:0] a_idx_reg, a_idx_next;
    logic        a_ally_reg, a_ally_next;
    logic        a_last_reg, a_last_next;
    logic        a_lpos_reg, a_lpos_next;
    logic [15:0] a_mx_reg, a_mx_next;
    logic [15:0] a_my_reg, a_my_next;

    logic [16:0] dx;
    logic [16:0] dy;
    logic [16:0] adx;
    logic [16:0] ady;

    assign full   = !(({1'b0, q_level} + {{LVL_W{1'b0}}, a_valid_reg}) < DEPTH_V);
    assign accept = push && !full;

    assign dx  = {self_x_reg[15], self_x_reg} - {pos_x[15], pos_x};
    assign dy  = {self_y_reg[15], self_y_reg} - {pos_y[15], pos_y};
    assign adx = dx[16] ? (17'd0 - dx) : dx;
    assign ady = dy[16] ? (17'd0 - dy) : dy;

    always_comb
    begin
        self_index_next = self_index_reg;
        self_team_next  = self_team_reg;
        self_x_next     = self_x_reg;
        self_y_next     = self_y_reg;
        a_kind_next     = a_kind_reg;
        a_idx_next      = a_idx_reg;
        a_ally_next     = a_ally_reg;
        a_last_next     = a_last_reg;
        a_lpos_next     = a_lpos_reg;
        a_mx_next       = a_mx_reg;
        a_my_next       = a_my_reg;
        if (accept)
        begin
            a_idx_next  = agent_index;
            a_last_next = last;
            if (trnq_kind_t'(req_type) == KIND_QUERY)
            begin
                // query: load asker, carry clamped radius for squaring
                self_index_next = agent_index;
                self_team_next  = team_id;
                self_x_next     = pos_x;
                self_y_next     = pos_y;
                a_kind_next     = KIND_QUERY;
                a_ally_next     = 1'b0;
                a_lpos_next     = (radius > 16'sd0);
                a_mx_next       = (radius > 16'sd0) ? radius : 16'd0;
                a_my_next       = 16'd0;
            end
            else
            begin
                a_kind_next = KIND_CAND;
                a_ally_next = (team_id == self_team_reg) && (agent_index != self_index_reg);
                a_lpos_next = 1'b0;
                a_mx_next   = adx[15:0];
                a_my_next   = ady[15:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg    <= 1'b0;
            self_index_reg <= '0;
            self_team_reg  <= '0;
            self_x_reg     <= '0;
            self_y_reg     <= '0;
        end
        else
        begin
            a_valid_reg    <= accept;
            self_index_reg <= self_index_next;
            self_team_reg  <= self_team_next;
            self_x_reg     <= self_x_next;
            self_y_reg     <= self_y_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_kind_reg <= a_kind_next;
        a_idx_reg  <= a_idx_next;
        a_ally_reg <= a_ally_next;
        a_last_reg <= a_last_next;
        a_lpos_reg <= a_lpos_next;
        a_mx_reg   <= a_mx_next;
        a_my_reg   <= a_my_next;
    end

    always_comb
    begin
        q_wr         = a_valid_reg;
        q_wdata.kind = a_kind_reg;
        q_wdata.idx  = a_idx_reg;
        q_wdata.ally = a_ally_reg;
        q_wdata.last = a_last_reg;
        q_wdata.lpos = a_lpos_reg;
        q_wdata.sqx  = a_mx_reg * a_mx_reg;
        q_wdata.sqy  = a_my_reg * a_my_reg;
    end

endmodule

`default_nettype wire

>>> design/trnq_queue.sv
// short queue of classified words between front and back
`default_nettype none

module trnq_queue
    import trnq_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    localparam int unsigned PTR_W      = $clog2(QUEUE_DEPTH),
    localparam int unsigned LVL_W      = $clog2(QUEUE_DEPTH + 1)
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         wr,
    input  wire trnq_entry_t  wdata,
    input  wire logic         rd,
    output logic              nonempty,
    output trnq_entry_t       rdata,
    output logic [LVL_W-1:0]  level
);

    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

    trnq_entry_t      mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] wptr_reg, wptr_next;
    logic [PTR_W-1:0] rptr_reg, rptr_next;
    logic [LVL_W-1:0] level_reg, level_next;
    logic             do_rd;

    assign nonempty = (level_reg != '0);
    assign do_rd    = rd && nonempty;
    assign rdata    = mem[rptr_reg];
    assign level    = level_reg;

    always_comb
    begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        level_next = level_reg;
        if (wr)
        begin
            wptr_next = (wptr_reg == PTR_LAST) ? '0 : wptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rptr_next = (rptr_reg == PTR_LAST) ? '0 : rptr_reg + 1'b1;
        end
        if (wr && !do_rd)
        begin
            level_next = level_reg + 1'b1;
        end
        else if (!wr && do_rd)
        begin
            level_next = level_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            level_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            level_reg <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            mem[wptr_reg] <= wdata;
        end
    end

endmodule

`default_nettype wire

>>> design/trnq_back.sv
// back end: count, nearest tracking and the result register
`default_nettype none

module trnq_back
    import trnq_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         cfg_we,
    input  wire logic [15:0]  cfg_wdata,
    input  wire logic         q_nonempty,
    input  wire trnq_entry_t  q_rdata,
    output logic              q_rd,
    output logic              res_valid,
    output trnq_result_t      res,
    input  wire logic         res_pop
);

    logic [15:0]  min_count_reg;
    logic [29:0]  limit_sq_reg, limit_sq_next;
    logic         limit_pos_reg, limit_pos_next;
    logic [15:0]  count_reg, count_next;
    logic         best_valid_reg, best_valid_next;
    logic [15:0]  best_index_reg, best_index_next;
    logic [32:0]  best_dist_reg, best_dist_next;
    logic         out_valid_reg, out_valid_next;
    trnq_result_t res_reg, res_next;

    logic         slot_free;
    logic         take;
    logic [32:0]  dsq;
    logic         hit;
    logic         better;

    assign slot_free = !out_valid_reg || res_pop;
    assign take      = q_nonempty && ((q_rdata.kind == KIND_QUERY) || slot_free);
    assign q_rd      = take;

    assign dsq    = {1'b0, q_rdata.sqx} + {1'b0, q_rdata.sqy};
    assign hit    = q_rdata.ally && (dsq <= {3'b000, limit_sq_reg});
    assign better = q_rdata.ally && (!best_valid_reg || (dsq < best_dist_reg) ||
                    ((dsq == best_dist_reg) && (q_rdata.idx < best_index_reg)));

    always_comb
    begin
        limit_sq_next   = limit_sq_reg;
        limit_pos_next  = limit_pos_reg;
        count_next      = count_reg;
        best_valid_next = best_valid_reg;
        best_index_next = best_index_reg;
        best_dist_next  = best_dist_reg;
        out_valid_next  = out_valid_reg && !res_pop;
        res_next        = res_reg;
        if (take)
        begin
            unique case (q_rdata.kind)
                KIND_QUERY:
                begin
                    limit_sq_next   = dsq[29:0];
                    limit_pos_next  = q_rdata.lpos;
                    count_next      = '0;
                    best_valid_next = 1'b0;
                    best_index_next = '0;
                    best_dist_next  = '0;
                end
                KIND_CAND:
                begin
                    if (hit && (count_reg != COUNT_MAX))
                    begin
                        count_next = count_reg + 16'd1;
                    end
                    if (better)
                    begin
                        best_valid_next = 1'b1;
                        best_index_next = q_rdata.idx;
                        best_dist_next  = dsq;
                    end
                    out_valid_next            = 1'b1;
                    res_next.cand_index       = q_rdata.idx;
                    res_next.in_radius        = hit;
                    res_next.ally_count       = count_next;
                    res_next.nearest_found    = best_valid_next;
                    res_next.nearest_index    = best_valid_next ? best_index_next : 16'd0;
                    res_next.nearest_dist_sq  = best_valid_next ? best_dist_next : 33'd0;
                    res_next.nearest_in_limit = best_valid_next && (!limit_pos_reg ||
                                                (best_dist_next <= {3'b000, limit_sq_reg}));
                    res_next.count_satisfied  = (count_next >= min_count_reg);
                    res_next.done_res         = q_rdata.last;
                end
                default:
                begin
                    out_valid_next = out_valid_reg && !res_pop;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_count_reg  <= MIN_COUNT_RST;
            limit_sq_reg   <= '0;
            limit_pos_reg  <= 1'b0;
            count_reg      <= '0;
            best_valid_reg <= 1'b0;
            best_index_reg <= '0;
            best_dist_reg  <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                min_count_reg <= cfg_wdata;
            end
            limit_sq_reg   <= limit_sq_next;
            limit_pos_reg  <= limit_pos_next;
            count_reg      <= count_next;
            best_valid_reg <= best_valid_next;
            best_index_reg <= best_index_next;
            best_dist_reg  <= best_dist_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign res_valid = out_valid_reg;
    assign res       = res_reg;

endmodule

`default_nettype wire

>>> design/trnq_checker.sv
// port-level checks for the team radius nearest query block, with bind
`default_nettype none

module trnq_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        empty,
    input  wire logic        pop,
    input  wire logic [15:0] cand_index,
    input  wire logic        in_radius,
    input  wire logic [15:0] ally_count,
    input  wire logic        nearest_found,
    input  wire logic [15:0] nearest_index,
    input  wire logic [32:0] nearest_dist_sq,
    input  wire logic        nearest_in_limit,
    input  wire logic        done_res
);

    // a stalled result word holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(cand_index) && $stable(ally_count)
                              && $stable(nearest_dist_sq) && $stable(done_res)))
        else $error("result word changed while stalled");

    // no nearest ally means zeroed nearest fields
    a_no_best: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !nearest_found) |-> (nearest_index == 16'd0 &&
                                        nearest_dist_sq == 33'd0 && !nearest_in_limit))
        else $error("nearest fields set without a nearest ally");

    // an ally in radius implies a nearest ally exists and is in limit
    a_hit_best: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && in_radius) |-> (nearest_found && nearest_in_limit))
        else $error("in-radius ally without an in-limit nearest");

    // an ally in radius has been counted
    a_hit_count: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && in_radius) |-> (ally_count != 16'd0))
        else $error("in-radius ally not counted");

endmodule

bind team_radius_nearest_query_top trnq_checker u_trnq_checker (.*);

`default_nettype wire
